@@ rtl/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, constants and pattern helpers for the turn signal sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

  localparam int LAMPS_PER_SIDE = 4;
  localparam int LAMP_FIELD_W   = 4;
  localparam int MODE_W         = 3;
  localparam int MS_W           = 10;
  // phase index and phase count must both fit
  localparam int PHASE_W        = $clog2(LAMPS_PER_SIDE + 2);
  localparam int LAMP_EXT_W     = (LAMPS_PER_SIDE > LAMP_FIELD_W) ? LAMPS_PER_SIDE
                                                                  : LAMP_FIELD_W;

  localparam logic [MODE_W-1:0] MODE_ALL_BLINK = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FILL      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RUN       = 3'd7;

  localparam logic [MS_W-1:0] MS_BLINK     = 10'd500;
  localparam logic [MS_W-1:0] MS_FILL_STEP = 10'd150;
  localparam logic [MS_W-1:0] MS_RUN_STEP  = 10'd100;
  localparam logic [MS_W-1:0] MS_GAP       = 10'd400;

  typedef logic [LAMPS_PER_SIDE-1:0] lamps_t;

  typedef enum logic [1:0] {
    SIDE_NONE  = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_t;

  typedef struct packed {
    logic left_request;
    logic right_request;
  } in_beat_t;

  typedef struct packed {
    logic [LAMP_FIELD_W-1:0] left_lamps;
    logic [LAMP_FIELD_W-1:0] right_lamps;
    logic [1:0]              active_side;
  } out_beat_t;

  typedef struct packed {
    side_t              side;
    logic [PHASE_W-1:0] phase;
    logic [MS_W-1:0]    ms;
    lamps_t             lamps;
  } seq_state_t;

  function automatic logic [PHASE_W-1:0] phase_count(input logic [MODE_W-1:0] mode);
    logic [PHASE_W-1:0] cnt;
    cnt = '0;
    if (mode == MODE_ALL_BLINK) begin
      cnt = PHASE_W'(2);
    end else if (mode == MODE_FILL || mode == MODE_RUN) begin
      cnt = PHASE_W'(LAMPS_PER_SIDE + 1);
    end
    return cnt;
  endfunction

  function automatic lamps_t phase_lamps(input logic [MODE_W-1:0] mode,
                                         input logic [PHASE_W-1:0] k);
    lamps_t one;
    lamps_t lamps;
    one   = lamps_t'(1);
    lamps = '0;
    if (mode == MODE_ALL_BLINK) begin
      lamps = (k == '0) ? '1 : '0;
    end else if (k < PHASE_W'(LAMPS_PER_SIDE)) begin
      if (mode == MODE_FILL) begin
        lamps = ~('1 << (k + PHASE_W'(1)));
      end else begin
        lamps = one << k;
      end
    end
    return lamps;
  endfunction

  function automatic logic [MS_W-1:0] phase_ms(input logic [MODE_W-1:0] mode,
                                                input logic [PHASE_W-1:0] k);
    logic [MS_W-1:0] ms;
    if (mode == MODE_ALL_BLINK) begin
      ms = MS_BLINK;
    end else if (k < PHASE_W'(LAMPS_PER_SIDE)) begin
      ms = (mode == MODE_FILL) ? MS_FILL_STEP : MS_RUN_STEP;
    end else begin
      ms = MS_GAP;
    end
    return ms;
  endfunction

  function automatic logic [LAMP_FIELD_W-1:0] lamp_field(input lamps_t lamps);
    logic [LAMP_EXT_W-1:0] ext;
    ext = LAMP_EXT_W'(lamps);
    return ext[LAMP_FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/turn_signal_pattern_sequencer_top.sv @@
// A beat waits in the input register until the result register can take it.
// Throughput: one beat per cycle while the output is not stalled; the input register feeds the
// result register through one pass of the step logic, and the sequencer state advances with it.
// Reset (rst_n low, synchronous): no side active, lamps dark, mode 0, both stages empty.
// ----------------------------------------------------------------------------
// turn_signal_pattern_sequencer_top
// Turn signal lamp sequencer with input and result register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module turn_signal_pattern_sequencer_top
  import tss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [MODE_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_beat_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_beat_t              out_data
);

  logic [MODE_W-1:0] mode_r;
  logic              stage_valid_r;
  in_beat_t          stage_beat_r;
  logic              out_valid_r;
  out_beat_t         out_beat_r;
  seq_state_t        state_r;
  seq_state_t        state_nxt;
  out_beat_t         res_nxt;
  logic              advance;

  assign advance   = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stage_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

  tss_step u_step (
    .mode (mode_r),
    .req  (stage_beat_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_ALL_BLINK;
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r       <= '{side: SIDE_NONE, phase: '0, ms: '0, lamps: '0};
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (in_ready) begin
        stage_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_beat_r <= in_data;
    end
    if (advance) begin
      out_beat_r <= res_nxt;
    end
  end

  // a running phase always belongs to a side
  a_ms_has_side: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.ms != '0) |-> (state_r.side != SIDE_NONE))
    else $error("phase timer running with no side");

  // lamps only light on the reported side
  a_lamps_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_beat_r.left_lamps == '0 || out_beat_r.active_side == SIDE_LEFT) &&
                     (out_beat_r.right_lamps == '0 || out_beat_r.active_side == SIDE_RIGHT)))
    else $error("lamps lit on inactive side");

  // sequencer state only moves when a beat passes to the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(advance)) |-> $stable(state_r))
    else $error("state changed without a beat");

endmodule

`default_nettype wire

@@ rtl/tss_step.sv @@
// ----------------------------------------------------------------------------
// tss_step
// Per-tick sequencer update: phase advance, side choice and lamp outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_step
  import tss_pkg::*;
(
  input  wire logic [MODE_W-1:0] mode,
  input  wire in_beat_t          req,
  input  wire seq_state_t        cur,
  output seq_state_t             nxt,
  output out_beat_t              res
);

  logic [PHASE_W-1:0] cnt;
  logic [PHASE_W-1:0] next_phase;
  side_t              pick;
  seq_state_t         upd;

  assign cnt        = phase_count(mode);
  assign next_phase = cur.phase + PHASE_W'(1);

  always_comb begin
    priority if (req.left_request) begin
      pick = SIDE_LEFT;
    end else if (req.right_request) begin
      pick = SIDE_RIGHT;
    end else begin
      pick = SIDE_NONE;
    end
  end

  always_comb begin
    upd = cur;
    if (cur.ms == '0) begin
      if (cur.side != SIDE_NONE && next_phase < cnt) begin
        upd.phase = next_phase;
        upd.lamps = phase_lamps(mode, next_phase);
        upd.ms    = phase_ms(mode, next_phase);
      end else begin
        upd.side  = pick;
        upd.phase = '0;
        upd.lamps = '0;
        // empty modes keep ms at zero so the choice repeats every tick
        if (pick != SIDE_NONE && cnt != '0) begin
          upd.lamps = phase_lamps(mode, '0);
          upd.ms    = phase_ms(mode, '0);
        end
      end
    end
  end

  always_comb begin
    res.left_lamps  = (upd.side == SIDE_LEFT)  ? lamp_field(upd.lamps) : '0;
    res.right_lamps = (upd.side == SIDE_RIGHT) ? lamp_field(upd.lamps) : '0;
    res.active_side = upd.side;
  end

  always_comb begin
    nxt = upd;
    if (upd.ms != '0) begin
      nxt.ms = upd.ms - MS_W'(1);
    end
  end

endmodule

`default_nettype wire
